[rtl/mcal_pkg.sv]
// Shared constants, types and the sensitivity table of the magnetometer calibration unit.
`default_nettype none

package mcal_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned RECIP_W  = 14;
   localparam int unsigned PROD_W   = COUNT_W + RECIP_W + 1;
   localparam int unsigned GAUSS_W  = PROD_W - 8;
   localparam int unsigned FIELD_W  = 24;
   localparam int unsigned CORR_W   = FIELD_W + 1;
   localparam int unsigned COEF_W   = 18;
   localparam int unsigned ROW_W    = 3 * COEF_W;
   localparam int unsigned MPROD_W  = COEF_W + CORR_W;
   localparam int unsigned ACC_W    = MPROD_W + 2;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned SHIFT_W  = ACC_W - FRAC_W;
   localparam int unsigned SCALE_W  = 2;
   localparam int unsigned INDEX_W  = 3;

   localparam logic [ROW_W-1:0] ROW0_RESET = ROW_W'(64'd65536);
   localparam logic [ROW_W-1:0] ROW1_RESET = ROW_W'(64'd65536 << COEF_W);
   localparam logic [ROW_W-1:0] ROW2_RESET = ROW_W'(64'd65536 << (2 * COEF_W));

   localparam logic signed [FIELD_W-1:0] SAT_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
   localparam logic signed [FIELD_W-1:0] SAT_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

   typedef enum logic [INDEX_W-1:0] {
      REG_FULL_SCALE = 3'd0,
      REG_OFFSET_X   = 3'd1,
      REG_OFFSET_Y   = 3'd2,
      REG_OFFSET_Z   = 3'd3,
      REG_MATRIX_ROW0 = 3'd4,
      REG_MATRIX_ROW1 = 3'd5,
      REG_MATRIX_ROW2 = 3'd6
   } reg_index_type;

   // Q0.24 reciprocal of the sensitivity, rounded, for each range.
   function automatic logic [RECIP_W-1:0] recip_of(input logic [SCALE_W-1:0] scale);
      logic [RECIP_W-1:0] r;
      case (scale)
         2'd0:    r = RECIP_W'(2452);
         2'd1:    r = RECIP_W'(4904);
         2'd2:    r = RECIP_W'(7355);
         2'd3:    r = RECIP_W'(9806);
         default: r = RECIP_W'(2452);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/magnetometer_calibration_unit.sv]
// Top level of the magnetometer calibration unit: four-stage pipeline and register file.
//
// Each req_ word carries the six output bytes of a three-axis magnetometer
// (little-endian x, y, z). Each rsp_ word carries the calibrated field of the
// three axes in signed Q7.16 gauss, saturated to 24 bits, and a clipped flag
// that is set when any axis saturated.
// The csr_ channel writes one of the seven registers by index; it is always
// ready and indexes beyond the last register are ignored. The user must write
// registers only while no word is in flight; the block does not enforce this.
// A word is offered on rsp_ once it has passed through every stage register. One
// word is accepted every cycle while the receiver takes results, because each of
// the four register stages (scale multiply, offset subtract, nine matrix
// multiplies, row sum and saturate) hands its word on in every cycle that the
// next stage can take it.
// When the receiver stalls, the pipeline stages fill one by one and req_ready
// falls once every stage holds a word; nothing is dropped or repeated.
// Synchronous reset empties the pipeline, selects the 4 gauss range, clears
// the offsets and loads the identity matrix.
`default_nettype none

module magnetometer_calibration_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,

   input  wire logic                                   req_valid,
   output      logic                                   req_ready,
   input  wire logic [mcal_pkg::BYTE_W-1:0]            req_x_low,
   input  wire logic [mcal_pkg::BYTE_W-1:0]            req_x_high,
   input  wire logic [mcal_pkg::BYTE_W-1:0]            req_y_low,
   input  wire logic [mcal_pkg::BYTE_W-1:0]            req_y_high,
   input  wire logic [mcal_pkg::BYTE_W-1:0]            req_z_low,
   input  wire logic [mcal_pkg::BYTE_W-1:0]            req_z_high,

   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   output      logic signed [mcal_pkg::FIELD_W-1:0]    rsp_field_x,
   output      logic signed [mcal_pkg::FIELD_W-1:0]    rsp_field_y,
   output      logic signed [mcal_pkg::FIELD_W-1:0]    rsp_field_z,
   output      logic                                   rsp_clipped,

   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [mcal_pkg::INDEX_W-1:0]           csr_index,
   input  wire logic [mcal_pkg::ROW_W-1:0]             csr_data
);

   // Configuration registers.
   logic [mcal_pkg::SCALE_W-1:0]        full_scale_ff;
   logic signed [mcal_pkg::FIELD_W-1:0] offset_ff [3];
   logic [mcal_pkg::ROW_W-1:0]          row_ff    [3];

   // Pipeline valids and enables.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_en, s2_en, s3_en, s4_en;

   // Stage payloads.
   logic signed [mcal_pkg::PROD_W-1:0]  s1_prod_ff [3];
   logic signed [mcal_pkg::PROD_W-1:0]  s1_prod_in [3];
   logic signed [mcal_pkg::CORR_W-1:0]  s2_corr_ff [3];
   logic signed [mcal_pkg::CORR_W-1:0]  s2_corr_in [3];
   logic signed [mcal_pkg::MPROD_W-1:0] s3_mprod_ff [3][3];
   logic signed [mcal_pkg::MPROD_W-1:0] s3_mprod_in [3][3];
   logic signed [mcal_pkg::FIELD_W-1:0] s4_field_ff [3];
   logic signed [mcal_pkg::FIELD_W-1:0] s4_field_in [3];
   logic                                s4_clip_ff;
   logic                                s4_clip_in;

   logic signed [mcal_pkg::COUNT_W-1:0] count [3];
   logic signed [mcal_pkg::RECIP_W:0]   recip_s;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= '0;
         offset_ff[0]  <= '0;
         offset_ff[1]  <= '0;
         offset_ff[2]  <= '0;
         row_ff[0]     <= mcal_pkg::ROW0_RESET;
         row_ff[1]     <= mcal_pkg::ROW1_RESET;
         row_ff[2]     <= mcal_pkg::ROW2_RESET;
      end else if (csr_valid) begin
         case (mcal_pkg::reg_index_type'(csr_index))
            mcal_pkg::REG_FULL_SCALE:  full_scale_ff <= csr_data[mcal_pkg::SCALE_W-1:0];
            mcal_pkg::REG_OFFSET_X:    offset_ff[0]  <= csr_data[mcal_pkg::FIELD_W-1:0];
            mcal_pkg::REG_OFFSET_Y:    offset_ff[1]  <= csr_data[mcal_pkg::FIELD_W-1:0];
            mcal_pkg::REG_OFFSET_Z:    offset_ff[2]  <= csr_data[mcal_pkg::FIELD_W-1:0];
            mcal_pkg::REG_MATRIX_ROW0: row_ff[0]     <= csr_data;
            mcal_pkg::REG_MATRIX_ROW1: row_ff[1]     <= csr_data;
            mcal_pkg::REG_MATRIX_ROW2: row_ff[2]     <= csr_data;
            default: ;
         endcase
      end
   end

   // A stage takes a new word when it is empty or its content moves on.
   assign s4_en     = !s4_valid_ff || rsp_ready;
   assign s3_en     = !s3_valid_ff || s4_en;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_en) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_en) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // Stage 1: raw count times the reciprocal sensitivity.
   always_comb begin
      count[0] = {req_x_high, req_x_low};
      count[1] = {req_y_high, req_y_low};
      count[2] = {req_z_high, req_z_low};
      recip_s  = {1'b0, mcal_pkg::recip_of(full_scale_ff)};
      for (int a = 0; a < 3; a++) begin
         s1_prod_in[a] = mcal_pkg::PROD_W'(count[a] * recip_s);
      end
   end

   // Stage 2: floor to Q7.16 and subtract the hard-iron offset.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         s2_corr_in[a] = mcal_pkg::CORR_W'(s1_prod_ff[a] >>> 8)
                       - mcal_pkg::CORR_W'(offset_ff[a]);
      end
   end

   // Stage 3: the nine soft-iron products.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            s3_mprod_in[r][c] = mcal_pkg::MPROD_W'(
               $signed(row_ff[r][c*mcal_pkg::COEF_W +: mcal_pkg::COEF_W]) * s2_corr_ff[c]);
         end
      end
   end

   // Stage 4: row sums, floor by 16 bits and saturation.
   always_comb begin
      logic signed [mcal_pkg::ACC_W-1:0]   acc;
      logic signed [mcal_pkg::SHIFT_W-1:0] shifted;
      s4_clip_in = 1'b0;
      for (int r = 0; r < 3; r++) begin
         acc = mcal_pkg::ACC_W'(s3_mprod_ff[r][0]) + mcal_pkg::ACC_W'(s3_mprod_ff[r][1])
             + mcal_pkg::ACC_W'(s3_mprod_ff[r][2]);
         shifted = acc[mcal_pkg::ACC_W-1:mcal_pkg::FRAC_W];
         if (shifted > mcal_pkg::SHIFT_W'(mcal_pkg::SAT_MAX)) begin
            s4_field_in[r] = mcal_pkg::SAT_MAX;
            s4_clip_in     = 1'b1;
         end else if (shifted < mcal_pkg::SHIFT_W'(mcal_pkg::SAT_MIN)) begin
            s4_field_in[r] = mcal_pkg::SAT_MIN;
            s4_clip_in     = 1'b1;
         end else begin
            s4_field_in[r] = shifted[mcal_pkg::FIELD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_prod_ff <= s1_prod_in;
      end
      if (s2_en) begin
         s2_corr_ff <= s2_corr_in;
      end
      if (s3_en) begin
         s3_mprod_ff <= s3_mprod_in;
      end
      if (s4_en) begin
         s4_field_ff <= s4_field_in;
         s4_clip_ff  <= s4_clip_in;
      end
   end

   assign rsp_valid   = s4_valid_ff;
   assign rsp_field_x = s4_field_ff[0];
   assign rsp_field_y = s4_field_ff[1];
   assign rsp_field_z = s4_field_ff[2];
   assign rsp_clipped = s4_clip_ff;

endmodule

`default_nettype wire

[tb/tb_magnetometer_calibration_unit.sv]
// Self-checking testbench for the magnetometer calibration unit: directed and random words.
module tb_magnetometer_calibration_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [mcal_pkg::INDEX_W-1:0] REG_NONE = 3'd7;

   typedef struct packed {
      logic [mcal_pkg::BYTE_W-1:0] x_low;
      logic [mcal_pkg::BYTE_W-1:0] x_high;
      logic [mcal_pkg::BYTE_W-1:0] y_low;
      logic [mcal_pkg::BYTE_W-1:0] y_high;
      logic [mcal_pkg::BYTE_W-1:0] z_low;
      logic [mcal_pkg::BYTE_W-1:0] z_high;
   } sample_type;

   typedef struct packed {
      logic signed [mcal_pkg::FIELD_W-1:0] field_x;
      logic signed [mcal_pkg::FIELD_W-1:0] field_y;
      logic signed [mcal_pkg::FIELD_W-1:0] field_z;
      logic                                clipped;
   } field_set_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   sample_type                          req_word;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [mcal_pkg::FIELD_W-1:0] rsp_field_x;
   logic signed [mcal_pkg::FIELD_W-1:0] rsp_field_y;
   logic signed [mcal_pkg::FIELD_W-1:0] rsp_field_z;
   logic                                rsp_clipped;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [mcal_pkg::INDEX_W-1:0]        csr_index;
   logic [mcal_pkg::ROW_W-1:0]          csr_data;

   // Shadow copy of the register file, used by the field predictor.
   logic [mcal_pkg::SCALE_W-1:0] cfg_scale;
   logic [mcal_pkg::FIELD_W-1:0] cfg_offset [3];
   logic [mcal_pkg::ROW_W-1:0]   cfg_matrix [3];

   field_set_type pending_fields [$];
   field_set_type arrived;
   int            mismatch_count = 0;
   int            cycle_count = 0;
   bit            calm;
   int            req_idle_pct;
   int            rsp_idle_pct;

   magnetometer_calibration_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_x_low   (req_word.x_low),
      .req_x_high  (req_word.x_high),
      .req_y_low   (req_word.y_low),
      .req_y_high  (req_word.y_high),
      .req_z_low   (req_word.z_low),
      .req_z_high  (req_word.z_high),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_field_x (rsp_field_x),
      .rsp_field_y (rsp_field_y),
      .rsp_field_z (rsp_field_z),
      .rsp_clipped (rsp_clipped),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Scale each count to gauss, remove the hard-iron offset, then apply the soft-iron matrix.
   function automatic field_set_type calibrate(input sample_type s);
      field_set_type r;
      longint        recip;
      longint        acc;
      longint        corr [3];
      longint        axis_out [3];
      logic [15:0]   pair [3];
      pair[0] = {s.x_high, s.x_low};
      pair[1] = {s.y_high, s.y_low};
      pair[2] = {s.z_high, s.z_low};
      case (cfg_scale)
         2'd0:    recip = 2452;
         2'd1:    recip = 4904;
         2'd2:    recip = 7355;
         default: recip = 9806;
      endcase
      r.clipped = 1'b0;
      for (int a = 0; a < 3; a++) begin
         corr[a] = ((longint'($signed(pair[a])) * recip) >>> 8)
                   - longint'($signed(cfg_offset[a]));
      end
      for (int row = 0; row < 3; row++) begin
         acc = 0;
         for (int col = 0; col < 3; col++) begin
            acc += longint'($signed(cfg_matrix[row][mcal_pkg::COEF_W*col +: mcal_pkg::COEF_W]))
                   * corr[col];
         end
         acc = acc >>> mcal_pkg::FRAC_W;
         if (acc > longint'(mcal_pkg::SAT_MAX)) begin
            acc = longint'(mcal_pkg::SAT_MAX);
            r.clipped = 1'b1;
         end else if (acc < longint'(mcal_pkg::SAT_MIN)) begin
            acc = longint'(mcal_pkg::SAT_MIN);
            r.clipped = 1'b1;
         end
         axis_out[row] = acc;
      end
      r.field_x = mcal_pkg::FIELD_W'(axis_out[0]);
      r.field_y = mcal_pkg::FIELD_W'(axis_out[1]);
      r.field_z = mcal_pkg::FIELD_W'(axis_out[2]);
      return r;
   endfunction

   task automatic check_value(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_fields.size() == 0) begin
            $error("result word with nothing outstanding: field_x %0d", rsp_field_x);
            mismatch_count++;
         end else begin
            arrived = pending_fields.pop_front();
            check_value("field_x", arrived.field_x, rsp_field_x);
            check_value("field_y", arrived.field_y, rsp_field_y);
            check_value("field_z", arrived.field_z, rsp_field_z);
            check_value("clipped", arrived.clipped, rsp_clipped);
         end
      end
   end

   // Random receiver back-pressure in bursts, started by rsp_idle_pct and never while calm.
   initial begin : rsp_stall
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else if (!calm && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_ready <= 1'b0;
            hold = $urandom_range(1, 9) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_sample(input sample_type s);
      int gap;
      if (!calm && $urandom_range(0, 99) < req_idle_pct) begin
         gap = $urandom_range(1, 9);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= s;
      do @(posedge clock); while (!req_ready);
      pending_fields.push_back(calibrate(s));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_fields.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mcal_pkg::INDEX_W-1:0] idx,
                            input logic [mcal_pkg::ROW_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         mcal_pkg::REG_FULL_SCALE:  cfg_scale     = value[mcal_pkg::SCALE_W-1:0];
         mcal_pkg::REG_OFFSET_X:    cfg_offset[0] = value[mcal_pkg::FIELD_W-1:0];
         mcal_pkg::REG_OFFSET_Y:    cfg_offset[1] = value[mcal_pkg::FIELD_W-1:0];
         mcal_pkg::REG_OFFSET_Z:    cfg_offset[2] = value[mcal_pkg::FIELD_W-1:0];
         mcal_pkg::REG_MATRIX_ROW0: cfg_matrix[0] = value;
         mcal_pkg::REG_MATRIX_ROW1: cfg_matrix[1] = value;
         mcal_pkg::REG_MATRIX_ROW2: cfg_matrix[2] = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [mcal_pkg::ROW_W-1:0] rand_data();
      logic [mcal_pkg::ROW_W-1:0] v;
      v = mcal_pkg::ROW_W'({$urandom, $urandom});
      return v;
   endfunction

   function automatic sample_type make_sample(input logic [15:0] x, input logic [15:0] y,
                                              input logic [15:0] z);
      return {x[7:0], x[15:8], y[7:0], y[15:8], z[7:0], z[15:8]};
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      s = sample_type'(48'({$urandom, $urandom}));
      // Now and then keep the counts close to zero.
      if ($urandom_range(0, 7) == 0) begin
         s.x_high = {mcal_pkg::BYTE_W{s.x_high[0]}};
         s.y_high = {mcal_pkg::BYTE_W{s.y_high[0]}};
         s.z_high = {mcal_pkg::BYTE_W{s.z_high[0]}};
      end
      return s;
   endfunction

   // Upper bits of the write data are random so that truncation is exercised too.
   task automatic write_offsets(input logic [mcal_pkg::FIELD_W-1:0] ox,
                                input logic [mcal_pkg::FIELD_W-1:0] oy,
                                input logic [mcal_pkg::FIELD_W-1:0] oz);
      logic [mcal_pkg::ROW_W-1:0] v;
      v = rand_data();
      v[mcal_pkg::FIELD_W-1:0] = ox;
      write_reg(mcal_pkg::REG_OFFSET_X, v);
      v[mcal_pkg::FIELD_W-1:0] = oy;
      write_reg(mcal_pkg::REG_OFFSET_Y, v);
      v[mcal_pkg::FIELD_W-1:0] = oz;
      write_reg(mcal_pkg::REG_OFFSET_Z, v);
   endtask

   task automatic write_matrix(input logic [mcal_pkg::ROW_W-1:0] r0,
                               input logic [mcal_pkg::ROW_W-1:0] r1,
                               input logic [mcal_pkg::ROW_W-1:0] r2);
      write_reg(mcal_pkg::REG_MATRIX_ROW0, r0);
      write_reg(mcal_pkg::REG_MATRIX_ROW1, r1);
      write_reg(mcal_pkg::REG_MATRIX_ROW2, r2);
   endtask

   task automatic test_default_setting();
      send_sample(make_sample(16'h0000, 16'h0000, 16'h0000));
      send_sample(make_sample(16'h7FFF, 16'h8000, 16'hFFFF));
      send_sample(make_sample(16'h8000, 16'h7FFF, 16'h0001));
   endtask

   task automatic test_ranges();
      logic [mcal_pkg::ROW_W-1:0] v;
      for (int sc = 0; sc < 4; sc++) begin
         wait_drained();
         v = rand_data();
         v[mcal_pkg::SCALE_W-1:0] = mcal_pkg::SCALE_W'(sc);
         write_reg(mcal_pkg::REG_FULL_SCALE, v);
         send_sample(make_sample(16'h7FFF, 16'h8000, 16'h0100));
         send_sample(make_sample(16'h8000, 16'h7FFF, 16'hFF00));
      end
   endtask

   task automatic test_hard_iron();
      wait_drained();
      write_offsets(mcal_pkg::SAT_MAX, mcal_pkg::SAT_MIN, '0);
      send_sample(make_sample(16'h8000, 16'h7FFF, 16'h1234));
      send_sample(make_sample(16'h7FFF, 16'h8000, 16'h0000));
      wait_drained();
      write_offsets(mcal_pkg::SAT_MIN, mcal_pkg::SAT_MAX, mcal_pkg::SAT_MAX);
      send_sample(make_sample(16'h7FFF, 16'h8000, 16'h8000));
      send_sample(make_sample(16'h8000, 16'h7FFF, 16'h7FFF));
   endtask

   task automatic test_soft_iron();
      wait_drained();
      // Most negative offsets and extreme entries drive row 0 past the upper limit and row 1 past the lower.
      write_offsets(mcal_pkg::SAT_MIN, mcal_pkg::SAT_MIN, mcal_pkg::SAT_MIN);
      write_matrix({3{18'h1FFFF}}, {3{18'h20000}}, {18'h00000, 18'h1FFFF, 18'h20000});
      send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_sample(make_sample(16'h8000, 16'h8000, 16'h8000));
      wait_drained();
      write_matrix('0, '0, '0);
      send_sample(make_sample(16'h7FFF, 16'h8000, 16'h4321));
      wait_drained();
      write_offsets('0, '0, '0);
      write_matrix(mcal_pkg::ROW0_RESET, mcal_pkg::ROW1_RESET, mcal_pkg::ROW2_RESET);
      send_sample(make_sample(16'h1234, 16'hEDCB, 16'h0F0F));
   endtask

   task automatic test_unused_index();
      wait_drained();
      write_reg(REG_NONE, rand_data());
      write_reg(REG_NONE, '1);
      send_sample(random_sample());
   endtask

   task automatic randomise_setting();
      logic [mcal_pkg::ROW_W-1:0] v;
      int                         entry;
      write_reg(mcal_pkg::REG_FULL_SCALE, rand_data());
      for (int a = 0; a < 3; a++) begin
         v = rand_data();
         if ($urandom_range(0, 1) == 1) begin
            v[mcal_pkg::FIELD_W-1:0] =
               mcal_pkg::FIELD_W'(int'($urandom_range(0, 262143)) - 131072);
         end
         write_reg(mcal_pkg::reg_index_type'(mcal_pkg::REG_OFFSET_X + a), v);
      end
      for (int row = 0; row < 3; row++) begin
         v = rand_data();
         if ($urandom_range(0, 2) != 0) begin
            for (int col = 0; col < 3; col++) begin
               entry = (col == row ? 65536 : 0) + int'($urandom_range(0, 16383)) - 8192;
               v[mcal_pkg::COEF_W*col +: mcal_pkg::COEF_W] = mcal_pkg::COEF_W'(entry);
            end
         end
         write_reg(mcal_pkg::reg_index_type'(mcal_pkg::REG_MATRIX_ROW0 + row), v);
      end
   endtask

   task automatic test_random_stream(input int phases, input int per_phase);
      for (int p = 0; p < phases; p++) begin
         wait_drained();
         randomise_setting();
         calm = (p == phases - 1);
         req_idle_pct = (p % 3 == 0) ? 0 : $urandom_range(5, 35);
         rsp_idle_pct = (p % 3 == 0) ? 0 : $urandom_range(5, 35);
         for (int i = 0; i < per_phase; i++) begin
            // Hold off once until every outstanding word has come back.
            if (p == 1 && i == per_phase / 2) begin
               wait_drained();
            end
            send_sample(random_sample());
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_word     = '0;
      rsp_ready    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      calm         = 1'b0;
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      cfg_scale    = '0;
      cfg_offset   = '{'0, '0, '0};
      cfg_matrix   = '{mcal_pkg::ROW0_RESET, mcal_pkg::ROW1_RESET, mcal_pkg::ROW2_RESET};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_setting();
      test_ranges();
      test_hard_iron();
      test_soft_iron();
      test_unused_index();
      test_random_stream(6, 90);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[magnetometer_calibration_unit.f]
rtl/mcal_pkg.sv
rtl/magnetometer_calibration_unit.sv
tb/tb_magnetometer_calibration_unit.sv
